// ----- hdl/fber_pkg.sv -----
// ----------------------------------------------------------------------------
// fber_pkg: shared types and constants of the band energy ratio detector
// Payload structures of the sample and result channels, register indexes
// and the fixed constants of the band analysis.
// ----------------------------------------------------------------------------
package fber_pkg;

	localparam int WINDOW_SIZE_DEF = 512;
	localparam int MAX_FREQS_DEF   = 4;
	localparam int CHANNELS_DEF    = 4;

	localparam int FREQ_REGS   = 4;
	localparam int SAMPLE_RATE = 44100;
	localparam int BAND_LOW    = 13000;
	localparam int BAND_HIGH   = 20002;
	localparam int HALF_WIDTH  = 100;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_0     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_1     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_2     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_3     = 3'd4;

	typedef struct packed {
		logic signed [31:0] sample;
		logic [1:0]         channel;
		logic               frame_last;
		logic               range_last;
	} sample_item_t;

	typedef struct packed {
		logic [1:0]  out_channel;
		logic [1:0]  freq_slot;
		logic [31:0] band_sum;
		logic        invalid;
		logic        last;
	} result_item_t;

endpackage

// ----- hdl/fber_isqrt.sv -----
// ----------------------------------------------------------------------------
// fber_isqrt: iterative integer square root
// Digit-by-digit root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module fber_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			res_q  <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= value;
				res_q  <= '0;
				bit_q  <= 64'd1 << 62;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// ----- hdl/fft_band_energy_ratio.sv -----
// ----------------------------------------------------------------------------
// fft_band_energy_ratio: Hann-windowed FFT band power detector
// Collects frames of audio samples, transforms them with one shared
// butterfly datapath and accumulates per-channel band energy ratios.
// ----------------------------------------------------------------------------
// Usage: samples arrive on the sample channel (valid/ready), one transaction
// per sample. The first N accepted samples of a frame are stored in the
// frame memory, later ones are dropped. The transaction that carries
// frame_last starts the processing of the frame; sample_ready stays low
// until the frame has been fully handled. Processing of a frame: windowing
// (read, multiply, write per sample), radix-2 butterflies (one shared 33x33
// multiplier, four products per butterfly), the magnitude of each in-band
// bin (square root one bit per cycle) and the ratio division per listened
// frequency.
// When range_last comes with frame_last, one result transaction per active
// listened frequency is sent on the result channel, in slot order, through
// an output register; if the receiver stalls, the block waits with the
// register full and accepts no sample until the last result is loaded.
// Reset clears the sums, the invalid flags, the sample count and the
// registers; the frame and spectrum memories need no clearing.
// ----------------------------------------------------------------------------
module fft_band_energy_ratio #(
	parameter int WINDOW_SIZE = fber_pkg::WINDOW_SIZE_DEF,
	parameter int MAX_FREQS   = fber_pkg::MAX_FREQS_DEF,
	parameter int CHANNELS    = fber_pkg::CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  fber_pkg::sample_item_t            sample_data,
	output logic                              result_valid,
	input  logic                              result_ready,
	output fber_pkg::result_item_t            result_data,
	input  logic                              cfg_we,
	input  logic [fber_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [fber_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import fber_pkg::*;

	localparam int LOG2N  = $clog2(WINDOW_SIZE);
	localparam int HALF   = WINDOW_SIZE / 2;
	localparam int BF_W   = LOG2N - 1;
	localparam int STG_W  = $clog2(LOG2N);
	localparam int TOT_W  = 33 + LOG2N;
	localparam int NSUMS  = CHANNELS * MAX_FREQS;
	localparam int SUM_AW = (NSUMS > 1) ? $clog2(NSUMS) : 1;

	// Bins whose frequency lies strictly inside the analysis band, up to bin N/2-2.
	localparam int BIN_LO  = (BAND_LOW * WINDOW_SIZE) / SAMPLE_RATE + 1;
	localparam int BIN_HI  = (BAND_HIGH * WINDOW_SIZE + SAMPLE_RATE - 1) / SAMPLE_RATE - 1;
	localparam int BIN_END = (BIN_HI < HALF - 2) ? BIN_HI : HALF - 2;
	localparam bit HAS_BINS = (BIN_LO <= BIN_END);
	localparam int FK_LO   = BIN_LO * SAMPLE_RATE;

	localparam longint unsigned Q30_ONE    = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int SIN_DIVS [6] = '{156, 110, 72, 42, 20, 6};
	localparam int COS_DIVS [6] = '{132, 90, 56, 30, 12, 2};

	// ------------------------------------------------------------------
	// Constant tables, evaluated at elaboration with the Q30 series.
	// ------------------------------------------------------------------
	function automatic longint unsigned poly_q30(input longint unsigned x2,
		input bit is_sin);
		longint unsigned inner;
		longint unsigned t;
		inner = Q30_ONE;
		for (int i = 0; i < 6; i++) begin
			if (is_sin)
				t = ((x2 * inner) >> 30) / SIN_DIVS[i];
			else
				t = ((x2 * inner) >> 30) / COS_DIVS[i];
			inner = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
		end
		return inner;
	endfunction

	// Returns {sin, cos} of 2*pi*num/den in Q30, den being N-1 or N.
	function automatic logic [63:0] sincos_q30(input int unsigned num,
		input bit hann_den);
		longint unsigned ph;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint s;
		longint c;
		logic [31:0] sn;
		logic [31:0] cs;
		if (hann_den)
			ph = (64'(num % (WINDOW_SIZE - 1)) << 32) / (WINDOW_SIZE - 1);
		else
			ph = (64'(num % WINDOW_SIZE) << 32) / WINDOW_SIZE;
		r  = ph & (Q30_ONE - 1);
		x  = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		s  = longint'((x * poly_q30(x2, 1'b1)) >> 30);
		c  = longint'(poly_q30(x2, 1'b0));
		case (ph[31:30])
			2'd0: begin sn = 32'(s);  cs = 32'(c);  end
			2'd1: begin sn = 32'(c);  cs = 32'(-s); end
			2'd2: begin sn = 32'(-s); cs = 32'(-c); end
			default: begin sn = 32'(-c); cs = 32'(s); end
		endcase
		return {sn, cs};
	endfunction

	typedef logic [15:0] hann_tab_t [WINDOW_SIZE];
	typedef logic [63:0] tw_tab_t [HALF];

	function automatic hann_tab_t build_hann();
		hann_tab_t tab;
		logic [63:0] sc;
		longint c;
		longint unsigned v;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			sc = sincos_q30(i, 1'b1);
			c  = longint'($signed(sc[31:0]));
			v  = (longint'(Q30_ONE) - c + 64'd32768) >> 16;
			tab[i] = (v > 64'd32768) ? 16'd32768 : v[15:0];
		end
		return tab;
	endfunction

	function automatic tw_tab_t build_tw();
		tw_tab_t tab;
		for (int i = 0; i < HALF; i++)
			tab[i] = sincos_q30(i, 1'b0);
		return tab;
	endfunction

	localparam hann_tab_t HANN_ROM = build_hann();
	localparam tw_tab_t   TW_ROM   = build_tw();

	function automatic logic [LOG2N-1:0] bit_rev(input logic [LOG2N-1:0] v);
		logic [LOG2N-1:0] r;
		for (int b = 0; b < LOG2N; b++)
			r[b] = v[LOG2N-1-b];
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (v < -35'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	// ------------------------------------------------------------------
	// Sequencer states
	// ------------------------------------------------------------------
	typedef enum logic [22:0] {
		ST_IDLE     = 23'd1 << 0,
		ST_WIN_RD   = 23'd1 << 1,
		ST_WIN_MUL  = 23'd1 << 2,
		ST_WIN_WR   = 23'd1 << 3,
		ST_BF_RD    = 23'd1 << 4,
		ST_BF_M0    = 23'd1 << 5,
		ST_BF_M1    = 23'd1 << 6,
		ST_BF_M2    = 23'd1 << 7,
		ST_BF_M3    = 23'd1 << 8,
		ST_BF_M4    = 23'd1 << 9,
		ST_BF_WA    = 23'd1 << 10,
		ST_BF_WB    = 23'd1 << 11,
		ST_MAG_RD   = 23'd1 << 12,
		ST_MAG_SQ0  = 23'd1 << 13,
		ST_MAG_SQ1  = 23'd1 << 14,
		ST_MAG_SQ2  = 23'd1 << 15,
		ST_MAG_SQRT = 23'd1 << 16,
		ST_MAG_ACC  = 23'd1 << 17,
		ST_DIV_INIT = 23'd1 << 18,
		ST_DIV_STEP = 23'd1 << 19,
		ST_DIV_ACC  = 23'd1 << 20,
		ST_EMIT     = 23'd1 << 21,
		ST_CLEAR    = 23'd1 << 22
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [2:0]  freq_count_q;
	logic [14:0] freq_q [FREQ_REGS];
	logic [2:0]  cnt_eff;

	// Frame bookkeeping.
	logic [LOG2N:0]   sample_cnt_q;
	logic [LOG2N:0]   frame_len_q;
	logic [1:0]       ch_q;
	logic             range_q;
	logic [LOG2N-1:0] idx_q;

	// Butterfly indexing.
	logic [STG_W-1:0] stage_q;
	logic [BF_W-1:0]  bf_q;
	logic [BF_W-1:0]  bf_mask;
	logic [LOG2N-1:0] addr_a;
	logic [LOG2N-1:0] addr_b;
	logic [BF_W-1:0]  tw_addr;

	// Memories and their read registers.
	logic [31:0] frame_mem [WINDOW_SIZE];
	logic [63:0] spec_mem  [WINDOW_SIZE];
	logic signed [31:0] frame_rd_q;
	logic [15:0] hann_q;
	logic [63:0] tw_q;
	logic [63:0] spec_a_q;
	logic [63:0] spec_b_q;
	logic        spec_rd_en;
	logic [LOG2N-1:0] spec_ra;
	logic        spec_we;
	logic [LOG2N-1:0] spec_wa;
	logic [63:0] spec_wd;

	// Shared multiplier.
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_full;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [34:0] tr_q;
	logic signed [34:0] ti_q;
	logic signed [64:0] tw_sum;
	logic signed [64:0] tw_dif;

	// Butterfly results.
	logic signed [31:0] ar;
	logic signed [31:0] ai;
	logic signed [31:0] br;
	logic signed [31:0] bi;
	logic signed [35:0] sum_re;
	logic signed [35:0] sum_im;
	logic signed [35:0] dif_re;
	logic signed [35:0] dif_im;
	logic [32:0] abs_re;
	logic [32:0] abs_im;

	// Magnitude and ratio.
	logic [LOG2N-1:0]   bin_q;
	logic signed [31:0] fk_q;
	logic [TOT_W-1:0]   total_q;
	logic [TOT_W-1:0]   part_q [MAX_FREQS];
	logic               sqrt_start;
	logic               sqrt_done;
	logic [31:0]        sqrt_root;
	logic [1:0]         slot_q;
	logic [TOT_W:0]     rem_q;
	logic [16:0]        quo_q;
	logic [4:0]         dstep_q;
	logic               div_ge;
	logic [TOT_W:0]     div_r1;
	logic [15:0]        ratio;
	logic [32:0]        acc_sum;

	// Sums and output register.
	logic [31:0]       band_sums_q [NSUMS];
	logic              sum_inv_q   [NSUMS];
	logic [SUM_AW-1:0] sum_idx;
	logic              out_valid_q;
	result_item_t      out_q;

	logic in_fire;
	logic slot_last;

	assign cnt_eff = (freq_count_q > 3'(MAX_FREQS)) ? 3'(MAX_FREQS) : freq_count_q;
	assign sample_ready = (state_q == ST_IDLE);
	assign in_fire = sample_valid && sample_ready;
	assign slot_last = ({1'b0, slot_q} + 3'd1) == cnt_eff;
	assign sum_idx = SUM_AW'(32'(ch_q) * MAX_FREQS + 32'(slot_q));

	// Butterfly addresses: a has a zero at bit "stage", b a one.
	assign bf_mask = (BF_W'(1) << stage_q) - BF_W'(1);
	assign addr_a  = {1'b0, bf_q & bf_mask} | {bf_q & ~bf_mask, 1'b0};
	assign addr_b  = addr_a | (LOG2N'(1) << stage_q);
	assign tw_addr = (bf_q & bf_mask) << (STG_W'(LOG2N - 1) - stage_q);

	assign ar = spec_a_q[63:32];
	assign ai = spec_a_q[31:0];
	assign br = spec_b_q[63:32];
	assign bi = spec_b_q[31:0];
	assign abs_re = ar[31] ? 33'(-{ar[31], ar}) : {1'b0, ar};
	assign abs_im = ai[31] ? 33'(-{ai[31], ai}) : {1'b0, ai};

	// Operand selection for the one multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_WIN_MUL: begin
				mul_a = {frame_rd_q[31], frame_rd_q};
				mul_b = {17'd0, hann_q};
			end
			ST_BF_M0: begin
				mul_a = {br[31], br};
				mul_b = {tw_q[31], tw_q[31:0]};
			end
			ST_BF_M1: begin
				mul_a = {bi[31], bi};
				mul_b = {tw_q[63], tw_q[63:32]};
			end
			ST_BF_M2: begin
				mul_a = {bi[31], bi};
				mul_b = {tw_q[31], tw_q[31:0]};
			end
			ST_BF_M3: begin
				mul_a = {br[31], br};
				mul_b = {tw_q[63], tw_q[63:32]};
			end
			ST_MAG_SQ0: begin
				mul_a = abs_re;
				mul_b = abs_re;
			end
			ST_MAG_SQ1: begin
				mul_a = abs_im;
				mul_b = abs_im;
			end
			default: ;
		endcase
	end

	assign mul_full = mul_a * mul_b;
	assign tw_sum = {acc_q[63], acc_q} + {prod_q[63], prod_q};
	assign tw_dif = {acc_q[63], acc_q} - {prod_q[63], prod_q};

	assign sum_re = {{4{ar[31]}}, ar} + {tr_q[34], tr_q};
	assign sum_im = {{4{ai[31]}}, ai} + {ti_q[34], ti_q};
	assign dif_re = {{4{ar[31]}}, ar} - {tr_q[34], tr_q};
	assign dif_im = {{4{ai[31]}}, ai} - {ti_q[34], ti_q};

	// Spectrum memory port control.
	always_comb begin
		spec_we = 1'b0;
		spec_wa = addr_a;
		spec_wd = '0;
		unique case (state_q)
			ST_WIN_WR: begin
				spec_we = 1'b1;
				spec_wa = bit_rev(idx_q);
				if ({1'b0, idx_q} < frame_len_q)
					spec_wd = {prod_q[46:15], 32'd0};
			end
			ST_BF_WA: begin
				spec_we = 1'b1;
				spec_wd = {sat32(sum_re[35:1]), sat32(sum_im[35:1])};
			end
			ST_BF_WB: begin
				spec_we = 1'b1;
				spec_wa = addr_b;
				spec_wd = {sat32(dif_re[35:1]), sat32(dif_im[35:1])};
			end
			default: ;
		endcase
	end

	assign spec_rd_en = (state_q == ST_BF_RD) || (state_q == ST_MAG_RD);
	assign spec_ra    = (state_q == ST_MAG_RD) ? bin_q : addr_a;

	always_ff @(posedge clk) begin
		if (in_fire && !sample_cnt_q[LOG2N])
			frame_mem[sample_cnt_q[LOG2N-1:0]] <= sample_data.sample;
		frame_rd_q <= frame_mem[idx_q];
		hann_q     <= HANN_ROM[idx_q];
		tw_q       <= TW_ROM[tw_addr];
	end

	always_ff @(posedge clk) begin
		if (spec_we)
			spec_mem[spec_wa] <= spec_wd;
		if (spec_rd_en) begin
			spec_a_q <= spec_mem[spec_ra];
			spec_b_q <= spec_mem[addr_b];
		end
	end

	fber_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.value (64'(acc_q) + 64'(prod_q)),
		.done  (sqrt_done),
		.root  (sqrt_root)
	);

	assign sqrt_start = (state_q == ST_MAG_SQ2);

	// One restoring division step: part * 2^16 / total, one quotient bit.
	assign div_ge = rem_q >= {1'b0, total_q};
	assign div_r1 = div_ge ? rem_q - {1'b0, total_q} : rem_q;
	assign ratio  = quo_q[16] ? 16'hFFFF : quo_q[15:0];
	assign acc_sum = {1'b0, band_sums_q[sum_idx]} + {17'd0, ratio};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			freq_count_q <= '0;
			for (int i = 0; i < FREQ_REGS; i++)
				freq_q[i] <= '0;
			sample_cnt_q <= '0;
			frame_len_q  <= '0;
			ch_q         <= '0;
			range_q      <= 1'b0;
			idx_q        <= '0;
			stage_q      <= '0;
			bf_q         <= '0;
			prod_q       <= '0;
			acc_q        <= '0;
			tr_q         <= '0;
			ti_q         <= '0;
			bin_q        <= '0;
			fk_q         <= '0;
			total_q      <= '0;
			for (int i = 0; i < MAX_FREQS; i++)
				part_q[i] <= '0;
			slot_q       <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			dstep_q      <= '0;
			for (int i = 0; i < NSUMS; i++) begin
				band_sums_q[i] <= '0;
				sum_inv_q[i]   <= 1'b0;
			end
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx) inside
					CFG_FREQ_COUNT: freq_count_q <= cfg_data[2:0];
					CFG_FREQ_0, CFG_FREQ_1, CFG_FREQ_2, CFG_FREQ_3:
						freq_q[2'(cfg_idx - CFG_FREQ_0)] <= cfg_data;
					default: ;
				endcase
			end

			if (result_valid && result_ready)
				out_valid_q <= 1'b0;

			prod_q <= mul_full[63:0];

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (sample_data.frame_last) begin
							sample_cnt_q <= '0;
							frame_len_q  <= sample_cnt_q +
								{LOG2N'(0), !sample_cnt_q[LOG2N]};
							ch_q    <= sample_data.channel;
							range_q <= sample_data.range_last;
							slot_q  <= '0;
							idx_q   <= '0;
							// Frames of channels at or beyond the CHANNELS parameter
							// are dropped and leave the sums and flags untouched.
							if (32'(sample_data.channel) >= CHANNELS)
								state_q <= ST_IDLE;
							else if (cnt_eff == 3'd0)
								state_q <= sample_data.range_last ? ST_CLEAR : ST_IDLE;
							else
								state_q <= ST_WIN_RD;
						end else if (!sample_cnt_q[LOG2N]) begin
							sample_cnt_q <= sample_cnt_q + 1'b1;
						end
					end
				end
				ST_WIN_RD:  state_q <= ST_WIN_MUL;
				ST_WIN_MUL: state_q <= ST_WIN_WR;
				ST_WIN_WR: begin
					if (idx_q == LOG2N'(WINDOW_SIZE - 1)) begin
						stage_q <= '0;
						bf_q    <= '0;
						state_q <= ST_BF_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_WIN_RD;
					end
				end
				ST_BF_RD: state_q <= ST_BF_M0;
				ST_BF_M0: state_q <= ST_BF_M1;
				ST_BF_M1: begin
					acc_q   <= prod_q;
					state_q <= ST_BF_M2;
				end
				ST_BF_M2: begin
					tr_q    <= tw_sum[64:30];
					state_q <= ST_BF_M3;
				end
				ST_BF_M3: begin
					acc_q   <= prod_q;
					state_q <= ST_BF_M4;
				end
				ST_BF_M4: begin
					ti_q    <= tw_dif[64:30];
					state_q <= ST_BF_WA;
				end
				ST_BF_WA: state_q <= ST_BF_WB;
				ST_BF_WB: begin
					bf_q <= bf_q + 1'b1;
					if (bf_q == {BF_W{1'b1}}) begin
						if (stage_q == STG_W'(LOG2N - 1)) begin
							bin_q   <= LOG2N'(BIN_LO);
							fk_q    <= 32'(FK_LO);
							total_q <= '0;
							for (int i = 0; i < MAX_FREQS; i++)
								part_q[i] <= '0;
							state_q <= HAS_BINS ? ST_MAG_RD : ST_DIV_INIT;
						end else begin
							stage_q <= stage_q + 1'b1;
							state_q <= ST_BF_RD;
						end
					end else begin
						state_q <= ST_BF_RD;
					end
				end
				ST_MAG_RD:  state_q <= ST_MAG_SQ0;
				ST_MAG_SQ0: state_q <= ST_MAG_SQ1;
				ST_MAG_SQ1: begin
					acc_q   <= prod_q;
					state_q <= ST_MAG_SQ2;
				end
				ST_MAG_SQ2: state_q <= ST_MAG_SQRT;
				ST_MAG_SQRT: begin
					if (sqrt_done)
						state_q <= ST_MAG_ACC;
				end
				ST_MAG_ACC: begin
					total_q <= total_q + TOT_W'(sqrt_root);
					// A bin counts toward a slot when it lies strictly
					// inside the window around that listened frequency.
					for (int s = 0; s < MAX_FREQS; s++) begin
						if (3'(s) < cnt_eff &&
							fk_q > ((32'($signed({17'd0, freq_q[s]})) - HALF_WIDTH) <<< LOG2N) &&
							fk_q < ((32'($signed({17'd0, freq_q[s]})) + HALF_WIDTH) <<< LOG2N))
							part_q[s] <= part_q[s] + TOT_W'(sqrt_root);
					end
					fk_q <= fk_q + SAMPLE_RATE;
					if (bin_q == LOG2N'(BIN_END)) begin
						state_q <= ST_DIV_INIT;
					end else begin
						bin_q   <= bin_q + 1'b1;
						state_q <= ST_MAG_RD;
					end
				end
				ST_DIV_INIT: begin
					if (total_q == '0) begin
						// Zero total energy: the sum stays, the flag is set.
						sum_inv_q[sum_idx] <= 1'b1;
						if (slot_last) begin
							slot_q  <= '0;
							state_q <= range_q ? ST_EMIT : ST_IDLE;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= ST_DIV_INIT;
						end
					end else begin
						rem_q   <= {1'b0, part_q[slot_q]};
						quo_q   <= '0;
						dstep_q <= '0;
						state_q <= ST_DIV_STEP;
					end
				end
				ST_DIV_STEP: begin
					rem_q   <= {div_r1[TOT_W-1:0], 1'b0};
					quo_q   <= {quo_q[15:0], div_ge};
					dstep_q <= dstep_q + 1'b1;
					if (dstep_q == 5'd16)
						state_q <= ST_DIV_ACC;
				end
				ST_DIV_ACC: begin
					band_sums_q[sum_idx] <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
					if (slot_last) begin
						slot_q  <= '0;
						state_q <= range_q ? ST_EMIT : ST_IDLE;
					end else begin
						slot_q  <= slot_q + 1'b1;
						state_q <= ST_DIV_INIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || result_ready) begin
						out_valid_q       <= 1'b1;
						out_q.out_channel <= ch_q;
						out_q.freq_slot   <= slot_q;
						out_q.band_sum    <= band_sums_q[sum_idx];
						out_q.invalid     <= sum_inv_q[sum_idx];
						out_q.last        <= slot_last;
						if (slot_last)
							state_q <= ST_CLEAR;
						else
							slot_q <= slot_q + 1'b1;
					end
				end
				ST_CLEAR: begin
					for (int s = 0; s < MAX_FREQS; s++) begin
						band_sums_q[SUM_AW'(32'(ch_q) * MAX_FREQS + s)] <= '0;
						sum_inv_q[SUM_AW'(32'(ch_q) * MAX_FREQS + s)]   <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

endmodule
